>>> hdl/gic_pkg.sv
`timescale 1ns / 1ps
// gic_pkg: shared types, codes and helper functions of the gamepad input conditioner.
// Used by gic_offset_ram and gamepad_input_conditioner; depends on nothing else.
package gic_pkg;

  // Action codes carried on the input channel.
  localparam logic [1:0] ACT_CONNECT    = 2'd0;
  localparam logic [1:0] ACT_DISCONNECT = 2'd1;
  localparam logic [1:0] ACT_REPORT     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_DEADZONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_SIDES     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_STICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVED    = 3'd4;
  localparam int unsigned CFG_DATA_W = 14;

  // Hat direction bits.
  localparam logic [3:0] HAT_UP    = 4'h1;
  localparam logic [3:0] HAT_RIGHT = 4'h2;
  localparam logic [3:0] HAT_DOWN  = 4'h4;
  localparam logic [3:0] HAT_LEFT  = 4'h8;

  // Saturation limits of a 16-bit axis.
  localparam logic signed [25:0] AXIS_MAX = 26'sd32767;
  localparam logic signed [25:0] AXIS_MIN = -26'sd32768;

  // Neutral offsets of one slot, as held in the offset memory.
  typedef struct packed {
    logic        [11:0] trig_r;
    logic        [11:0] trig_l;
    logic signed [15:0] ry;
    logic signed [15:0] rx;
    logic signed [15:0] ly;
    logic signed [15:0] lx;
  } gic_offs_t;

  // Map the protocol button mask onto the output button order.
  function automatic logic [16:0] remap_buttons(input logic [15:0] m, input logic swap);
    logic [16:0] b;
    b        = '0;
    b[0]     = m[4];
    b[1]     = m[5];
    b[2]     = m[6];
    b[3]     = m[7];
    b[4]     = m[3];
    b[5]     = m[0];
    b[6]     = m[2];
    b[7]     = m[14];
    b[8]     = m[15];
    b[9]     = swap ? m[13] : m[12];
    b[10]    = swap ? m[12] : m[13];
    b[11]    = m[8];
    b[12]    = m[9];
    b[13]    = m[10];
    b[14]    = m[11];
    return b;
  endfunction

  // Eight-way hat from the d-pad bits; opposing directions cancel to centered.
  function automatic logic [3:0] make_hat(input logic [15:0] m);
    logic [3:0] h;
    h = '0;
    if (!(m[8] && m[9]) && !(m[10] && m[11])) begin
      h = (m[8]  ? HAT_UP    : 4'h0) | (m[11] ? HAT_RIGHT : 4'h0)
        | (m[9]  ? HAT_DOWN  : 4'h0) | (m[10] ? HAT_LEFT  : 4'h0);
    end
    return h;
  endfunction

endpackage

>>> hdl/gic_offset_ram.sv
`timescale 1ns / 1ps
// gic_offset_ram: per-slot neutral offset memory, one write and one registered read port.
// Depends on gic_pkg for the offset record type.
module gic_offset_ram
  import gic_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  gic_offs_t     wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output gic_offs_t     rd_data
);

  gic_offs_t mem [DEPTH];
  gic_offs_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-before-write: a read and write of the same entry in one cycle returns the old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/gamepad_input_conditioner.sv
`timescale 1ns / 1ps
// Gamepad input conditioner, top level. Items pass through stage registers A, B, C and
// the output register. Throughput: one item per cycle while out_stall is low, set by the
// offset memory write and read at the input stage and a four-register pipeline behind it.
// Reset (rst_n, synchronous, active low) clears slot flags, pipeline valids and the
// configuration registers; the offset memory is not cleared and needs no clearing pass.
module gamepad_input_conditioner
  import gic_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [2:0]            in_slot,
  input  logic [15:0]           in_button_mask,
  input  logic [11:0]           in_left_trigger,
  input  logic [11:0]           in_right_trigger,
  input  logic signed [15:0]    in_left_x,
  input  logic signed [15:0]    in_left_y,
  input  logic signed [15:0]    in_right_x,
  input  logic signed [15:0]    in_right_y,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_slot_out,
  output logic signed [15:0]    out_axis_0,
  output logic signed [15:0]    out_axis_1,
  output logic signed [15:0]    out_axis_2,
  output logic signed [15:0]    out_axis_3,
  output logic signed [15:0]    out_axis_4,
  output logic signed [15:0]    out_axis_5,
  output logic [16:0]           out_button_bits,
  output logic [3:0]            out_hat,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the user only writes them
  // while the block is idle, so the pipeline reads them without capture.
  // ---------------------------------------------------------------------------
  logic [6:0]  stick_gain_r;
  logic [13:0] stick_deadzone_r;
  logic        swap_sides_r;
  logic        swap_sticks_r;
  logic        interleaved_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_gain_r     <= 7'd1;
      stick_deadzone_r <= 14'd500;
      swap_sides_r     <= 1'b0;
      swap_sticks_r    <= 1'b0;
      interleaved_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_STICK_GAIN:     stick_gain_r     <= cfg_data[6:0];
        CFG_STICK_DEADZONE: stick_deadzone_r <= cfg_data[13:0];
        CFG_SWAP_SIDES:     swap_sides_r     <= cfg_data[0];
        CFG_SWAP_STICKS:    swap_sticks_r    <= cfg_data[0];
        CFG_INTERLEAVED:    interleaved_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage takes a new item when it is empty or when
  // the stage behind it moves, so bubbles collapse and the input keeps flowing
  // while a finished result waits in the output register, until stages A to C fill.
  // ---------------------------------------------------------------------------
  logic va_r, vb_r, vc_r, out_valid_r;
  logic rdy_out, rdy_c, rdy_b, rdy_a;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy_c    = !vc_r || rdy_out;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_stall = !rdy_a;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Slot flags live in flip-flops and are updated at the transfer itself, so a
  // following item for the same slot always sees the new state.
  // ---------------------------------------------------------------------------
  logic [SLOT_COUNT-1:0] active_r, active_nxt;
  logic [SLOT_COUNT-1:0] calib_r, calib_nxt;
  logic [SLOT_AW-1:0]    slot_idx;
  logic                  slot_ok;
  logic                  cur_active, cur_calib;
  logic                  emit_connect;  // zero report for a fresh connect
  logic                  emit_report;   // report for an input item
  logic                  need_calib;    // first input since connect: latch offsets

  assign slot_idx   = SLOT_AW'(in_slot);
  assign slot_ok    = (32'(in_slot) < SLOT_COUNT);
  assign cur_active = active_r[slot_idx];
  assign cur_calib  = calib_r[slot_idx];

  always_comb begin
    active_nxt   = active_r;
    calib_nxt    = calib_r;
    emit_connect = 1'b0;
    emit_report  = 1'b0;
    need_calib   = 1'b0;
    if (in_xfer && slot_ok) begin
      unique case (in_action)
        ACT_CONNECT: begin
          if (!cur_active) begin
            active_nxt[slot_idx] = 1'b1;
            calib_nxt[slot_idx]  = 1'b0;
            emit_connect         = 1'b1;
          end
        end
        ACT_DISCONNECT: begin
          active_nxt[slot_idx] = 1'b0;
          calib_nxt[slot_idx]  = 1'b0;
        end
        ACT_REPORT: begin
          // An inactive slot connects implicitly and is therefore uncalibrated.
          need_calib           = !cur_active || !cur_calib;
          active_nxt[slot_idx] = 1'b1;
          calib_nxt[slot_idx]  = 1'b1;
          emit_report          = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      calib_r  <= '0;
    end else begin
      active_r <= active_nxt;
      calib_r  <= calib_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Offset memory. The first input after a connect writes its raw readings as
  // the neutral offsets in the same cycle it reads the entry. That item uses its
  // own readings, and any later item reads the memory after the write landed,
  // so no forwarding path is needed.
  // ---------------------------------------------------------------------------
  gic_offs_t raw_in;
  gic_offs_t ram_rd;

  always_comb begin
    raw_in.trig_l = in_left_trigger;
    raw_in.trig_r = in_right_trigger;
    raw_in.lx     = in_left_x;
    raw_in.ly     = in_left_y;
    raw_in.rx     = in_right_x;
    raw_in.ry     = in_right_y;
  end

  gic_offset_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SLOT_AW)
  ) u_offs (
    .clk     (clk),
    .wr_en   (need_calib),
    .wr_addr (slot_idx),
    .wr_data (raw_in),
    .rd_en   (in_xfer),
    .rd_addr (slot_idx),
    .rd_data (ram_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage A: item captured at the transfer. A connect enters with all readings
  // and buttons forced to zero and marked as calibrating, which gives the
  // all-zero report.
  // ---------------------------------------------------------------------------
  logic [2:0]  a_slot_r;
  logic        a_calib_r;
  gic_offs_t   a_raw_r;
  logic [16:0] a_btn_r;
  logic [3:0]  a_hat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= emit_connect || emit_report;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_slot_r  <= in_slot;
      a_calib_r <= emit_connect || need_calib;
      a_raw_r   <= emit_connect ? '0 : raw_in;
      a_btn_r   <= emit_connect ? '0 : remap_buttons(in_button_mask, swap_sides_r);
      a_hat_r   <= emit_connect ? '0 : make_hat(in_button_mask);
    end
  end

  // Offset subtraction, trigger magnitude, stick and side exchange.
  gic_offs_t          a_off;
  logic signed [16:0] d_lx, d_ly, d_rx, d_ry;
  logic signed [12:0] d_lt, d_rt;
  logic [11:0]        m_lt, m_rt;

  always_comb begin
    a_off = a_calib_r ? a_raw_r : ram_rd;
    d_lx  = 17'(a_raw_r.lx) - 17'(a_off.lx);
    d_ly  = 17'(a_raw_r.ly) - 17'(a_off.ly);
    d_rx  = 17'(a_raw_r.rx) - 17'(a_off.rx);
    d_ry  = 17'(a_raw_r.ry) - 17'(a_off.ry);
    d_lt  = $signed({1'b0, a_raw_r.trig_l}) - $signed({1'b0, a_off.trig_l});
    d_rt  = $signed({1'b0, a_raw_r.trig_r}) - $signed({1'b0, a_off.trig_r});
    // The difference of two 12-bit readings never exceeds 4095 in magnitude,
    // so the magnitude already lies within the trigger clamp.
    m_lt  = d_lt[12] ? 12'(-d_lt) : d_lt[11:0];
    m_rt  = d_rt[12] ? 12'(-d_rt) : d_rt[11:0];
  end

  // ---------------------------------------------------------------------------
  // Stage B.
  // ---------------------------------------------------------------------------
  logic [2:0]         b_slot_r;
  logic signed [16:0] b_lx_r, b_ly_r, b_rx_r, b_ry_r;
  logic [11:0]        b_t1_r, b_t2_r;
  logic [16:0]        b_btn_r;
  logic [3:0]         b_hat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      b_slot_r <= a_slot_r;
      b_lx_r   <= swap_sticks_r ? d_rx : d_lx;
      b_ly_r   <= swap_sticks_r ? d_ry : d_ly;
      b_rx_r   <= swap_sticks_r ? d_lx : d_rx;
      b_ry_r   <= swap_sticks_r ? d_ly : d_ry;
      b_t1_r   <= swap_sides_r ? m_rt : m_lt;
      b_t2_r   <= swap_sides_r ? m_lt : m_rt;
      b_btn_r  <= a_btn_r;
      b_hat_r  <= a_hat_r;
    end
  end

  // Y negation and deadzone. A value strictly inside (-deadzone, deadzone) is zero.
  logic signed [17:0] dz_pos, dz_neg;
  logic signed [17:0] s_lx, s_ly, s_rx, s_ry;
  logic signed [17:0] z_lx, z_ly, z_rx, z_ry;

  always_comb begin
    dz_pos = $signed({4'b0, stick_deadzone_r});
    dz_neg = -dz_pos;
    s_lx   = 18'(b_lx_r);
    s_ly   = -18'(b_ly_r);
    s_rx   = 18'(b_rx_r);
    s_ry   = -18'(b_ry_r);
    z_lx   = (s_lx > dz_neg && s_lx < dz_pos) ? '0 : s_lx;
    z_ly   = (s_ly > dz_neg && s_ly < dz_pos) ? '0 : s_ly;
    z_rx   = (s_rx > dz_neg && s_rx < dz_pos) ? '0 : s_rx;
    z_ry   = (s_ry > dz_neg && s_ry < dz_pos) ? '0 : s_ry;
  end

  // Trigger scaling v * 32767 / 4095, written as 8v + floor(7v / 4095). The
  // small quotient uses the identity floor(x / 4095) = (x + (x >> 12) + 1) >> 12,
  // which holds for every 7v of a 12-bit v.
  function automatic logic [14:0] scale_trigger(input logic [11:0] v);
    logic [14:0] x7;
    logic [15:0] acc;
    x7  = {v, 3'b000} - {3'b000, v};
    acc = {1'b0, x7} + 16'(x7[14:12]) + 16'd1;
    return {v, 3'b000} + 15'(acc[14:12]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stage C.
  // ---------------------------------------------------------------------------
  logic [2:0]         c_slot_r;
  logic signed [17:0] c_lx_r, c_ly_r, c_rx_r, c_ry_r;
  logic [14:0]        c_t1_r, c_t2_r;
  logic [16:0]        c_btn_r;
  logic [3:0]         c_hat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c) begin
      c_slot_r <= b_slot_r;
      c_lx_r   <= z_lx;
      c_ly_r   <= z_ly;
      c_rx_r   <= z_rx;
      c_ry_r   <= z_ry;
      c_t1_r   <= scale_trigger(b_t1_r);
      c_t2_r   <= scale_trigger(b_t2_r);
      c_btn_r  <= b_btn_r;
      c_hat_r  <= b_hat_r;
    end
  end

  // Gain and saturation to 16 bits.
  function automatic logic signed [15:0] apply_gain(input logic signed [17:0] v,
                                                    input logic [6:0]         g);
    logic signed [25:0] p;
    p = 26'(v) * 26'($signed({1'b0, g}));
    if (p > AXIS_MAX) begin
      return AXIS_MAX[15:0];
    end else if (p < AXIS_MIN) begin
      return AXIS_MIN[15:0];
    end
    return p[15:0];
  endfunction

  logic signed [15:0] g_lx, g_ly, g_rx, g_ry;
  logic signed [15:0] g_t1, g_t2;

  always_comb begin
    g_lx = apply_gain(c_lx_r, stick_gain_r);
    g_ly = apply_gain(c_ly_r, stick_gain_r);
    g_rx = apply_gain(c_rx_r, stick_gain_r);
    g_ry = apply_gain(c_ry_r, stick_gain_r);
    g_t1 = $signed({1'b0, c_t1_r});
    g_t2 = $signed({1'b0, c_t2_r});
  end

  // ---------------------------------------------------------------------------
  // Output register. The interleaved layout places the first trigger right
  // after the left stick; the default layout keeps both sticks together.
  // ---------------------------------------------------------------------------
  logic [2:0]         o_slot_r;
  logic signed [15:0] o_ax0_r, o_ax1_r, o_ax2_r, o_ax3_r, o_ax4_r, o_ax5_r;
  logic [16:0]        o_btn_r;
  logic [3:0]         o_hat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      o_slot_r <= c_slot_r;
      o_ax0_r  <= g_lx;
      o_ax1_r  <= g_ly;
      o_ax2_r  <= interleaved_r ? g_t1 : g_rx;
      o_ax3_r  <= interleaved_r ? g_rx : g_ry;
      o_ax4_r  <= interleaved_r ? g_ry : g_t1;
      o_ax5_r  <= g_t2;
      o_btn_r  <= c_btn_r;
      o_hat_r  <= c_hat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_out    = o_slot_r;
  assign out_axis_0      = o_ax0_r;
  assign out_axis_1      = o_ax1_r;
  assign out_axis_2      = o_ax2_r;
  assign out_axis_3      = o_ax3_r;
  assign out_axis_4      = o_ax4_r;
  assign out_axis_5      = o_ax5_r;
  assign out_button_bits = o_btn_r;
  assign out_hat         = o_hat_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of gamepad_input_conditioner: directed and random traffic with a
// transfer-level predictor of the per-slot calibration, stick and trigger shaping and button remap.
// Depends on gic_pkg (action codes, register indexes, hat bits) and the block under test.
module testbench;
  import gic_pkg::*;

  // The input channel can carry code 3, which the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int NUM_SLOTS      = 8;
  localparam int PIPE_LAT       = 3;
  localparam int SETTLE_CYCLES  = PIPE_LAT + 5;
  localparam int RAND_PER_PHASE = 150;
  localparam int HOLD_CYCLES    = 400;    // long receiver hold-off, fills the pipeline
  localparam int CYCLE_LIMIT    = 600000;
  localparam int AXIS_HI        = 32767;
  localparam int AXIS_LO        = -32768;
  localparam int TRIG_FULL      = 4095;

  // One item of the input channel.
  typedef struct packed {
    logic [1:0]         action;
    logic [2:0]         slot;
    logic [15:0]        mask;
    logic [11:0]        lt;
    logic [11:0]        rt;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } pad_item_t;

  // One conditioned report of the result channel.
  typedef struct packed {
    logic [2:0]         slot;
    logic signed [15:0] ax0;
    logic signed [15:0] ax1;
    logic signed [15:0] ax2;
    logic signed [15:0] ax3;
    logic signed [15:0] ax4;
    logic signed [15:0] ax5;
    logic [16:0]        btn;
    logic [3:0]         hat;
  } pad_report_t;

  typedef struct {
    int gain;
    int dz;
    bit sides;
    bit sticks;
    bit inter;
  } cfg_set_t;

  // ---------------------------------------------------------------------------------------
  // Clock and reset.
  // ---------------------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Ports of the block. Every input starts at a known value.
  // ---------------------------------------------------------------------------------------
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = ACT_CONNECT;
  logic [2:0]            in_slot = '0;
  logic [15:0]           in_button_mask = '0;
  logic [11:0]           in_left_trigger = '0;
  logic [11:0]           in_right_trigger = '0;
  logic signed [15:0]    in_left_x = '0;
  logic signed [15:0]    in_left_y = '0;
  logic signed [15:0]    in_right_x = '0;
  logic signed [15:0]    in_right_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_slot_out;
  logic signed [15:0]    out_axis_0;
  logic signed [15:0]    out_axis_1;
  logic signed [15:0]    out_axis_2;
  logic signed [15:0]    out_axis_3;
  logic signed [15:0]    out_axis_4;
  logic signed [15:0]    out_axis_5;
  logic [16:0]           out_button_bits;
  logic [3:0]            out_hat;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gamepad_input_conditioner #(
    .SLOT_COUNT(NUM_SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_slot          (in_slot),
    .in_button_mask   (in_button_mask),
    .in_left_trigger  (in_left_trigger),
    .in_right_trigger (in_right_trigger),
    .in_left_x        (in_left_x),
    .in_left_y        (in_left_y),
    .in_right_x       (in_right_x),
    .in_right_y       (in_right_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_slot_out     (out_slot_out),
    .out_axis_0       (out_axis_0),
    .out_axis_1       (out_axis_1),
    .out_axis_2       (out_axis_2),
    .out_axis_3       (out_axis_3),
    .out_axis_4       (out_axis_4),
    .out_axis_5       (out_axis_5),
    .out_button_bits  (out_button_bits),
    .out_hat          (out_hat),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // ---------------------------------------------------------------------------------------
  // Shared testbench state.
  // ---------------------------------------------------------------------------------------
  pad_item_t   pend_q[$];      // items waiting to be offered on the input channel
  pad_report_t report_q[$];    // predicted reports, oldest first
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  logic        pressure_go = 1'b0;

  // Predictor copy of the configuration registers, at their reset values.
  int cur_gain   = 1;
  int cur_dz     = 500;
  bit cur_sides  = 1'b0;
  bit cur_sticks = 1'b0;
  bit cur_inter  = 1'b0;

  // Predictor copy of the per-slot state.
  bit                 slot_live [NUM_SLOTS] = '{default: 1'b0};
  bit                 slot_cal  [NUM_SLOTS] = '{default: 1'b0};
  logic [11:0]        neu_lt [NUM_SLOTS];
  logic [11:0]        neu_rt [NUM_SLOTS];
  logic signed [15:0] neu_lx [NUM_SLOTS];
  logic signed [15:0] neu_ly [NUM_SLOTS];
  logic signed [15:0] neu_rx [NUM_SLOTS];
  logic signed [15:0] neu_ry [NUM_SLOTS];

  // Stretches without idling alternate between the two sides of the block.
  logic quiet_in;
  logic quiet_out;
  assign quiet_in  = ((cycle_cnt >> 9) & 3) == 0;
  assign quiet_out = ((cycle_cnt >> 9) & 3) == 2;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------------------

  // Deadzone, then gain, then saturation to the 16-bit axis range.
  function automatic logic signed [15:0] shape_stick(input int v);
    longint x;
    if (longint'(v) > -longint'(cur_dz) && longint'(v) < longint'(cur_dz)) begin
      return '0;
    end
    x = longint'(v) * longint'(cur_gain);
    if (x > AXIS_HI) x = AXIS_HI;
    if (x < AXIS_LO) x = AXIS_LO;
    return x[15:0];
  endfunction

  // Trigger deflection scaled from 0..4095 onto 0..32767, truncating.
  function automatic logic signed [15:0] scale_trigger(input int v);
    int t;
    t = v;
    if (t < 0) t = 0;
    if (t > TRIG_FULL) t = TRIG_FULL;
    t = (t * AXIS_HI) / TRIG_FULL;
    return t[15:0];
  endfunction

  // Output button i takes protocol bit src[i]; the shoulder pair may be exchanged.
  function automatic logic [16:0] map_buttons(input logic [15:0] m);
    int src [15] = '{4, 5, 6, 7, 3, 0, 2, 14, 15, 12, 13, 8, 9, 10, 11};
    logic [16:0] b;
    int j;
    b = '0;
    for (int i = 0; i < 15; i++) begin
      j = src[i];
      if (cur_sides && i == 9) j = 13;
      if (cur_sides && i == 10) j = 12;
      b[i] = m[j];
    end
    return b;
  endfunction

  // Opposing d-pad directions center the hat; three or more always contain such a pair.
  function automatic logic [3:0] dpad_hat(input logic [15:0] m);
    logic [3:0] h;
    if ((m[8] && m[9]) || (m[10] && m[11])) return 4'h0;
    h = 4'h0;
    if (m[8])  h = h | HAT_UP;
    if (m[11]) h = h | HAT_RIGHT;
    if (m[9])  h = h | HAT_DOWN;
    if (m[10]) h = h | HAT_LEFT;
    return h;
  endfunction

  function automatic pad_report_t build_report(input logic [2:0] s, input int tl, tr, lx, ly,
                                               rx, ry, input logic [15:0] m);
    pad_report_t r;
    int tx;
    int ty;
    logic signed [15:0] s_lx, s_ly, s_rx, s_ry, t1, t2;
    if (cur_sticks) begin
      tx = lx;
      ty = ly;
      lx = rx;
      ly = ry;
      rx = tx;
      ry = ty;
    end
    s_lx = shape_stick(lx);
    s_ly = shape_stick(-ly);
    s_rx = shape_stick(rx);
    s_ry = shape_stick(-ry);
    t1 = scale_trigger(cur_sides ? tr : tl);
    t2 = scale_trigger(cur_sides ? tl : tr);
    r.slot = s;
    r.ax0  = s_lx;
    r.ax1  = s_ly;
    if (cur_inter) begin
      r.ax2 = t1;
      r.ax3 = s_rx;
      r.ax4 = s_ry;
    end else begin
      r.ax2 = s_rx;
      r.ax3 = s_ry;
      r.ax4 = t1;
    end
    r.ax5 = t2;
    r.btn = map_buttons(m);
    r.hat = dpad_hat(m);
    return r;
  endfunction

  // Advances the slot state for one accepted item; returns 1 when a report results.
  function automatic bit predict_item(input pad_item_t it, output pad_report_t rep);
    int s;
    int dl;
    int dr;
    s = it.slot;
    rep = '0;
    case (it.action)
      ACT_CONNECT: begin
        if (slot_live[s]) return 1'b0;
        slot_live[s] = 1'b1;
        slot_cal[s]  = 1'b0;
        rep = build_report(it.slot, 0, 0, 0, 0, 0, 0, 16'h0000);
        return 1'b1;
      end
      ACT_DISCONNECT: begin
        slot_live[s] = 1'b0;
        slot_cal[s]  = 1'b0;
        return 1'b0;
      end
      ACT_REPORT: begin
        // A report on an idle slot connects it silently.
        if (!slot_live[s]) begin
          slot_live[s] = 1'b1;
          slot_cal[s]  = 1'b0;
        end
        // The first report after a connect defines the neutral position.
        if (!slot_cal[s]) begin
          neu_lt[s]   = it.lt;
          neu_rt[s]   = it.rt;
          neu_lx[s]   = it.lx;
          neu_ly[s]   = it.ly;
          neu_rx[s]   = it.rx;
          neu_ry[s]   = it.ry;
          slot_cal[s] = 1'b1;
        end
        dl = int'(it.lt) - int'(neu_lt[s]);
        dr = int'(it.rt) - int'(neu_rt[s]);
        if (dl < 0) dl = -dl;
        if (dr < 0) dr = -dr;
        rep = build_report(it.slot, dl, dr,
                           int'($signed(it.lx)) - int'($signed(neu_lx[s])),
                           int'($signed(it.ly)) - int'($signed(neu_ly[s])),
                           int'($signed(it.rx)) - int'($signed(neu_rx[s])),
                           int'($signed(it.ry)) - int'($signed(neu_ry[s])),
                           it.mask);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one.
  // ---------------------------------------------------------------------------------------
  function automatic int draw_gap(input logic quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input driver. A transfer happens at an edge where in_valid is high and in_stall low;
  // the prediction is made right there, so it always sees the configuration in force.
  // A stalled item keeps its payload, and back-to-back items keep in_valid high.
  // ---------------------------------------------------------------------------------------
  pad_item_t   drv_item;
  pad_report_t drv_rep;
  int          drv_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_item(drv_item, drv_rep)) report_q.push_back(drv_rep);
      end
      if (in_valid && in_stall) begin
        // Item stays on the channel unchanged until it is taken.
      end else if (drv_gap > 0) begin
        drv_gap = drv_gap - 1;
        in_valid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        drv_item = pend_q.pop_front();
        in_action        <= drv_item.action;
        in_slot          <= drv_item.slot;
        in_button_mask   <= drv_item.mask;
        in_left_trigger  <= drv_item.lt;
        in_right_trigger <= drv_item.rt;
        in_left_x        <= drv_item.lx;
        in_left_y        <= drv_item.ly;
        in_right_x       <= drv_item.rx;
        in_right_y       <= drv_item.ry;
        in_valid         <= 1'b1;
        drv_gap = draw_gap(quiet_in);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Receiver stall. Random stall stretches, plus one long hold-off counted here once the
  // stimulus asks for it; the sender keeps offering meanwhile, so the block backs up and
  // has to stall its input.
  // ---------------------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (pressure_go && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left = draw_gap(quiet_out);
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor. Every transfer on the result channel is matched, field by field,
  // against the oldest predicted report.
  // ---------------------------------------------------------------------------------------
  pad_report_t mon_want;

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $display("%0t: report for slot %0d with none expected, actual axes %0d %0d %0d",
                 $time, out_slot_out, out_axis_0, out_axis_1, out_axis_2);
        err_cnt++;
      end else begin
        mon_want = report_q.pop_front();
        compare_field("slot_out", mon_want.slot, out_slot_out);
        compare_field("axis_0", mon_want.ax0, out_axis_0);
        compare_field("axis_1", mon_want.ax1, out_axis_1);
        compare_field("axis_2", mon_want.ax2, out_axis_2);
        compare_field("axis_3", mon_want.ax3, out_axis_3);
        compare_field("axis_4", mon_want.ax4, out_axis_4);
        compare_field("axis_5", mon_want.ax5, out_axis_5);
        compare_field("button_bits", mon_want.btn, out_button_bits);
        compare_field("hat", mon_want.hat, out_hat);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  function automatic pad_item_t mk_item(input logic [1:0] act, input logic [2:0] s,
                                        input logic [15:0] m, input logic [11:0] lt, rt,
                                        input logic signed [15:0] lx, ly, rx, ry);
    pad_item_t it;
    it.action = act;
    it.slot   = s;
    it.mask   = m;
    it.lt     = lt;
    it.rt     = rt;
    it.lx     = lx;
    it.ly     = ly;
    it.rx     = rx;
    it.ry     = ry;
    return it;
  endfunction

  // One register write; the predictor copy changes at the transfer edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STICK_GAIN:     cur_gain   = val & 32'h7F;
      CFG_STICK_DEADZONE: cur_dz     = val & 32'h3FFF;
      CFG_SWAP_SIDES:     cur_sides  = val[0];
      CFG_SWAP_STICKS:    cur_sticks = val[0];
      CFG_INTERLEAVED:    cur_inter  = val[0];
      default: ;
    endcase
  endtask

  // Waits until every item is taken and every report is back, sampling between edges so
  // that the decision never races the driver, then lets the pipeline run empty.
  task automatic drain();
    do @(negedge clk); while (pend_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    cfg_set_t           plan [8];
    int                 base_st [NUM_SLOTS][4];
    int                 base_tr [NUM_SLOTS][2];
    logic signed [15:0] st [4];
    logic [11:0]        tr [2];
    int                 sel;
    int                 mode;
    logic [2:0]         sl;
    logic [1:0]         act;

    // Extremes first, then the range edges of the deadzone and gain, then random settings.
    plan[0] = '{gain: 1,   dz: 0,     sides: 1'b0, sticks: 1'b0, inter: 1'b0};
    plan[1] = '{gain: 64,  dz: 12000, sides: 1'b1, sticks: 1'b1, inter: 1'b1};
    plan[2] = '{gain: 127, dz: 16383, sides: 1'b0, sticks: 1'b1, inter: 1'b0};
    plan[3] = '{gain: 0,   dz: 500,   sides: 1'b1, sticks: 1'b0, inter: 1'b1};
    for (int p = 4; p < 8; p++) begin
      plan[p].gain   = $urandom_range(1, 64);
      plan[p].dz     = $urandom_range(0, 12000);
      plan[p].sides  = $urandom_range(0, 1);
      plan[p].sticks = $urandom_range(0, 1);
      plan[p].inter  = $urandom_range(0, 1);
    end
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int k = 0; k < 4; k++) base_st[s][k] = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < 2; k++) base_tr[s][k] = $urandom_range(0, 4095);
    end

    // Reset is applied once, at the start of the run.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset configuration (gain 1, deadzone 500).
    // A report on an idle slot connects it without a zero report and calibrates on itself.
    pend_q.push_back(mk_item(ACT_REPORT, 3'd0, 16'h0000, 12'd100, 12'd200,
                             16'sd1000, -16'sd1000, 16'sd5, 16'sd7));
    // Deflections just inside and just at the deadzone edge.
    pend_q.push_back(mk_item(ACT_REPORT, 3'd0, 16'h0110, 12'd4095, 12'd0,
                             16'sd1499, -16'sd1500, 16'sd505, -16'sd492));
    // Explicit connect gives a zero report; a second connect on a live slot is ignored.
    pend_q.push_back(mk_item(ACT_CONNECT, 3'd7, 16'hFFFF, 12'd4095, 12'd4095,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    pend_q.push_back(mk_item(ACT_CONNECT, 3'd7, 16'h0000, 12'd0, 12'd0,
                             16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    // Calibrate at the bottom of every range, then swing to the top: full saturation.
    pend_q.push_back(mk_item(ACT_REPORT, 3'd7, 16'hFFFF, 12'd0, 12'd0,
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd7, 16'h0000, 12'd4095, 12'd4095,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd7, 16'h0900, 12'd0, 12'd0,
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    // Disconnect, then a disconnect on an idle slot, then the unused action code.
    pend_q.push_back(mk_item(ACT_DISCONNECT, 3'd7, 16'h1234, 12'd1, 12'd2,
                             16'sd3, 16'sd4, 16'sd5, 16'sd6));
    pend_q.push_back(mk_item(ACT_DISCONNECT, 3'd7, 16'h0000, 12'd0, 12'd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_UNUSED, 3'd3, 16'hFFFF, 12'd4095, 12'd4095,
                             16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
    // Calibrate at the top, then swing to the bottom; the negated Y saturates high.
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0000, 12'd4095, 12'd4095,
                             16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0300, 12'd0, 12'd0,
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    // Hat: left with right, three directions, three diagonals and up alone.
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0C00, 12'd2000, 12'd3000,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0700, 12'd4095, 12'd0,
                             16'sd100, -16'sd100, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0600, 12'd0, 12'd4095,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0A00, 12'd4095, 12'd4095,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0500, 12'd1, 12'd4094,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h0100, 12'd0, 12'd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // Alternating button patterns and each shoulder alone.
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h5555, 12'd2048, 12'd2047,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'hAAAA, 12'd0, 12'd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h1000, 12'd0, 12'd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd3, 16'h2000, 12'd0, 12'd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    // Connect on an idle slot gives a zero report; its first report then calibrates.
    pend_q.push_back(mk_item(ACT_CONNECT, 3'd5, 16'h0000, 12'd0, 12'd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd0));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd5, 16'h8001, 12'd300, 12'd400,
                             -16'sd20000, 16'sd20000, 16'sd123, -16'sd123));
    pend_q.push_back(mk_item(ACT_REPORT, 3'd5, 16'h4004, 12'd0, 12'd4095,
                             16'sd12000, -16'sd12000, -16'sd700, 16'sd700));
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_STICK_GAIN, plan[p].gain);
      write_reg(CFG_STICK_DEADZONE, plan[p].dz);
      write_reg(CFG_SWAP_SIDES, plan[p].sides);
      write_reg(CFG_SWAP_STICKS, plan[p].sticks);
      write_reg(CFG_INTERLEAVED, plan[p].inter);

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        sel = $urandom_range(0, 99);
        sl  = 3'($urandom_range(0, NUM_SLOTS - 1));
        if (sel < 8) act = ACT_CONNECT;
        else if (sel < 15) act = ACT_DISCONNECT;
        else if (sel < 18) act = ACT_UNUSED;
        else act = ACT_REPORT;
        // A fresh session gets a fresh neutral point, which later reports hover around.
        if (act == ACT_CONNECT || act == ACT_DISCONNECT) begin
          for (int k = 0; k < 4; k++) base_st[sl][k] = int'($urandom_range(0, 65535)) - 32768;
          for (int k = 0; k < 2; k++) base_tr[sl][k] = $urandom_range(0, 4095);
        end
        for (int k = 0; k < 4; k++) begin
          mode = $urandom_range(0, 9);
          if (mode < 4) st[k] = 16'(base_st[sl][k] + int'($urandom_range(0, 2400)) - 1200);
          else if (mode < 8)
            st[k] = 16'(base_st[sl][k] + int'($urandom_range(0, 32000)) - 16000);
          else st[k] = 16'($urandom());
        end
        for (int k = 0; k < 2; k++) begin
          if ($urandom_range(0, 1) == 0)
            tr[k] = 12'(base_tr[sl][k] + int'($urandom_range(0, 600)) - 300);
          else tr[k] = 12'($urandom());
        end
        pend_q.push_back(mk_item(act, sl, 16'($urandom()), tr[0], tr[1],
                                 st[0], st[1], st[2], st[3]));
      end
      // During the first random phase the receiver holds off for a long stretch.
      if (p == 0) pressure_go <= 1'b1;
      drain();
    end

    if (err_cnt == 0) begin
      $display("gamepad_input_conditioner: match");
    end else begin
      $display("gamepad_input_conditioner: mismatch");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing report ends the run here.
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("gamepad_input_conditioner: mismatch");
    $finish;
  end

endmodule
